>>> rtl/rtalu_pkg.sv
// ----------------------------------------------------------------------------
// rtalu_pkg
// Shared types, codes and sizes for the R-type ALU with register file.
// ----------------------------------------------------------------------------
package rtalu_pkg;

   localparam int REG_COUNT = 32;
   localparam int REG_AW    = $clog2(REG_COUNT);
   localparam int DATA_W    = 32;

   // item kinds
   localparam logic [1:0] FUNC_EXEC = 2'd0;
   localparam logic [1:0] FUNC_LOAD = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;

   // result status
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVF       = 2'd1;
   localparam logic [1:0] ST_NOT_R     = 2'd2;
   localparam logic [1:0] ST_BAD_FUNCT = 2'd3;

   // opcode / funct codes
   localparam logic [5:0] OP_RTYPE = 6'h00;
   localparam logic [5:0] FN_SLL   = 6'h00;
   localparam logic [5:0] FN_SRL   = 6'h02;
   localparam logic [5:0] FN_ADD   = 6'h20;
   localparam logic [5:0] FN_SUB   = 6'h22;
   localparam logic [5:0] FN_AND   = 6'h24;
   localparam logic [5:0] FN_OR    = 6'h25;
   localparam logic [5:0] FN_SLT   = 6'h2A;

   typedef struct packed {
      logic [1:0]        func;
      logic [31:0]       instruction;
      logic [REG_AW-1:0] reg_index;
      logic [DATA_W-1:0] load_value;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [REG_AW-1:0] dest_index;
      logic [DATA_W-1:0] result_value;
      logic              wrote;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] addr;
      logic [DATA_W-1:0] data;
   } wr_type;

   // read port A address: rs for instructions, reg_index otherwise
   function automatic logic [REG_AW-1:0] addr_a(input req_type r);
      logic [REG_AW-1:0] a;
      a = (r.func == FUNC_EXEC) ? r.instruction[25:21] : r.reg_index;
      return a;
   endfunction

   // read port B address: rt
   function automatic logic [REG_AW-1:0] addr_b(input req_type r);
      return r.instruction[20:16];
   endfunction

endpackage

>>> rtl/rtalu_ram.sv
// ----------------------------------------------------------------------------
// rtalu_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module rtalu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

>>> rtl/rtalu_regfile.sv
// ----------------------------------------------------------------------------
// rtalu_regfile
// Register file: RAM plus per-entry valid bits (reset to zero) and a
// bypass of the most recent write, which a read issued on the same edge misses.
// ----------------------------------------------------------------------------
module rtalu_regfile
   import rtalu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [REG_AW-1:0] rd_addr_a,
   input  logic [REG_AW-1:0] rd_addr_b,
   input  wr_type            wr,
   output logic [DATA_W-1:0] op_a,
   output logic [DATA_W-1:0] op_b
);

   logic [REG_COUNT-1:0] vld_ff;
   logic [REG_COUNT-1:0] vld_in;
   logic [REG_AW-1:0]    addr_a_ff;
   logic [REG_AW-1:0]    addr_b_ff;
   logic                 fwd_vld_ff;
   logic [REG_AW-1:0]    fwd_addr_ff;
   logic [DATA_W-1:0]    fwd_data_ff;
   logic [DATA_W-1:0]    ram_a;
   logic [DATA_W-1:0]    ram_b;

   rtalu_ram #(
      .WIDTH (DATA_W),
      .DEPTH (REG_COUNT)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr.en),
      .wr_addr   (wr.addr),
      .wr_data   (wr.data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (ram_a),
      .rd_data_b (ram_b)
   );

   always_comb begin
      vld_in = vld_ff;
      if (wr.en && (wr.addr != '0)) begin
         vld_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         fwd_vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (wr.en) begin
            fwd_vld_ff <= 1'b1;
         end
      end
      addr_a_ff <= rd_addr_a;
      addr_b_ff <= rd_addr_b;
      if (wr.en) begin
         fwd_addr_ff <= wr.addr;
         fwd_data_ff <= wr.data;
      end
   end

   // newest write wins; never-written entries (and entry 0) read zero
   always_comb begin
      if (fwd_vld_ff && (fwd_addr_ff == addr_a_ff)) begin
         op_a = fwd_data_ff;
      end else if (vld_ff[addr_a_ff]) begin
         op_a = ram_a;
      end else begin
         op_a = '0;
      end
      if (fwd_vld_ff && (fwd_addr_ff == addr_b_ff)) begin
         op_b = fwd_data_ff;
      end else if (vld_ff[addr_b_ff]) begin
         op_b = ram_b;
      end else begin
         op_b = '0;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      !vld_ff[0])
      else $error("register 0 marked as written");

endmodule

>>> rtl/rtalu_exec.sv
// ----------------------------------------------------------------------------
// rtalu_exec
// Decode and ALU: forms the result beat and the register write for one item.
// ----------------------------------------------------------------------------
module rtalu_exec
   import rtalu_pkg::*;
(
   input  req_type           req,
   input  logic [DATA_W-1:0] op_a,
   input  logic [DATA_W-1:0] op_b,
   output rsp_type           rsp,
   output wr_type            wr
);

   logic [5:0]        opcode;
   logic [REG_AW-1:0] rd;
   logic [4:0]        shamt;
   logic [5:0]        funct;
   logic [DATA_W-1:0] sum;
   logic [DATA_W-1:0] diff;
   logic [DATA_W-1:0] alu;
   logic [1:0]        alu_st;

   assign opcode = req.instruction[31:26];
   assign rd     = req.instruction[15:11];
   assign shamt  = req.instruction[10:6];
   assign funct  = req.instruction[5:0];
   assign sum    = op_a + op_b;
   assign diff   = op_a - op_b;

   always_comb begin
      alu    = '0;
      alu_st = ST_OK;
      unique case (funct)
         FN_ADD: begin
            alu = sum;
            if (!(op_a[DATA_W-1] ^ op_b[DATA_W-1]) && (op_a[DATA_W-1] ^ sum[DATA_W-1]))
               alu_st = ST_OVF;
         end
         FN_SUB: begin
            alu = diff;
            if ((op_a[DATA_W-1] ^ op_b[DATA_W-1]) && (op_a[DATA_W-1] ^ diff[DATA_W-1]))
               alu_st = ST_OVF;
         end
         FN_AND: alu = op_a & op_b;
         FN_OR:  alu = op_a | op_b;
         FN_SLL: alu = op_b << shamt;
         FN_SRL: alu = op_b >> shamt;
         FN_SLT: alu = {{(DATA_W-1){1'b0}}, ($signed(op_a) < $signed(op_b))};
         default: alu_st = ST_BAD_FUNCT;
      endcase
   end

   always_comb begin
      rsp = '0;
      wr  = '0;
      unique case (req.func)
         FUNC_EXEC: begin
            if (opcode != OP_RTYPE) begin
               rsp.status = ST_NOT_R;
            end else begin
               rsp.status       = alu_st;
               rsp.dest_index   = rd;
               rsp.result_value = alu;
               wr.en            = (alu_st == ST_OK) && (rd != '0);
               wr.addr          = rd;
               wr.data          = alu;
            end
         end
         FUNC_LOAD: begin
            rsp.dest_index   = req.reg_index;
            rsp.result_value = req.load_value;
            wr.en            = (req.reg_index != '0);
            wr.addr          = req.reg_index;
            wr.data          = req.load_value;
         end
         FUNC_READ: begin
            rsp.dest_index   = req.reg_index;
            rsp.result_value = op_a;
         end
         default: ;
      endcase
      rsp.wrote = wr.en;
   end

endmodule

>>> rtl/r_type_alu_register_file.sv
// ----------------------------------------------------------------------------
// r_type_alu_register_file
// R-type execute stage with a 32 x 32-bit register file.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one beat per item (execute word, load register, read register).
//            A beat is taken on a rising edge with req_valid high and
//            req_stall low.
//   rsp_*  : exactly one result beat per request beat, in order. The
//            receiver holds the beat off by raising rsp_stall.
// Path: a taken request reaches rsp_valid through the registered read of
//   the register file RAM followed by the result register.
// Throughput: one beat per cycle while rsp_stall is low; a write from one
//   item is bypassed to the next, so dependent items follow back to back.
// Stall: while the result register is full and stalled, the execute stage
//   holds its item and req_stall rises; the RAM read is reissued each
//   cycle for the held item so its operands stay current.
// Reset: synchronous, active high. Drops all beats in flight and clears the
//   valid bits, so every register reads zero; no clearing pass is needed
//   and a request may be taken in the first cycle after reset.
// ----------------------------------------------------------------------------
module r_type_alu_register_file
   import rtalu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // execute stage: item whose operands are coming out of the RAM
   logic              s1_vld_ff;
   logic              s1_vld_in;
   req_type           s1_ff;
   // result register
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_type           rsp_data_ff;

   logic              accept;
   logic              advance;
   logic [REG_AW-1:0] rd_addr_a;
   logic [REG_AW-1:0] rd_addr_b;
   logic [DATA_W-1:0] op_a;
   logic [DATA_W-1:0] op_b;
   rsp_type           exec_rsp;
   wr_type            exec_wr;
   wr_type            wr;

   // execute stage moves on when the result register is free or draining
   assign advance   = s1_vld_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign s1_vld_in    = accept || (s1_vld_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // read addresses: the new beat if one is taken, else re-read the held item
   assign rd_addr_a = accept ? addr_a(req_data) : addr_a(s1_ff);
   assign rd_addr_b = accept ? addr_b(req_data) : addr_b(s1_ff);

   rtalu_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .wr        (wr),
      .op_a      (op_a),
      .op_b      (op_b)
   );

   rtalu_exec u_exec (
      .req  (s1_ff),
      .op_a (op_a),
      .op_b (op_b),
      .rsp  (exec_rsp),
      .wr   (exec_wr)
   );

   // write back only when the item leaves the execute stage
   always_comb begin
      wr    = exec_wr;
      wr.en = exec_wr.en && advance;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_vld_ff    <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         s1_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= exec_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a reported write always means status ok and a nonzero destination
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.wrote) |-> (rsp_data.status == ST_OK && rsp_data.dest_index != '0))
      else $error("write reported with bad status or register 0");

   // the register file is written only as an item moves to the result register
   assert property (@(posedge clock) disable iff (reset)
      wr.en |=> rsp_valid_ff)
      else $error("write without a result beat");

   // back pressure only with a held item in the execute stage
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_vld_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled without cause");

   // nothing in flight right after reset
   assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !s1_vld_ff))
      else $error("beat in flight after reset");

endmodule

>>> tb/sv/r_type_alu_register_file_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// r_type_alu_register_file_test
// Self-checking bench for the R-type execute stage and its register file.
// A shadow register file predicts every result beat from the request beats
// as they are taken. A directed pass covers the overflow corners, shifts and
// slt, register 0 and bad words. Random passes follow, with and without
// idling, plus a long result hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module r_type_alu_register_file_test;
   import rtalu_pkg::*;

   // item kind with no effect; the package has no name for it
   localparam logic [1:0] FUNC_IGNORED = 2'd3;
   // cycles with no beat on either side before the run is declared hung
   localparam int WATCHDOG_LIMIT = 1000;
   // long receiver hold-off used to fill the block up
   localparam int HOLD_CYCLES = 120;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   r_type_alu_register_file dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // supported ALU functs, for random picks
   logic [5:0] alu_functs [7] = '{FN_SLL, FN_SRL, FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLT};

   // shadow copy of the register file; entry 0 is never written
   logic [DATA_W-1:0] shadow_regs [REG_COUNT];
   rsp_type           pending_rsp [$];
   int                mismatches = 0;

   // idling controls, flipped by the test tasks
   bit sender_idle_on = 1'b1;
   bit rsp_idle_on    = 1'b1;
   bit hold_request   = 1'b0;
   int hold_left      = 0;

   // Handshake flags and both payloads are sampled at the falling edge.
   // All inputs change only at the rising edge, so these are exactly the
   // values the block sees at the next rising edge, with no ordering race.
   bit      req_take = 1'b0;
   bit      rsp_take = 1'b0;
   req_type req_seen;
   rsp_type rsp_seen;

   initial begin
      for (int i = 0; i < REG_COUNT; i++) shadow_regs[i] = '0;
   end

   always @(negedge clock) begin
      req_take = !reset && (req_valid === 1'b1) && (req_stall === 1'b0);
      rsp_take = !reset && (rsp_valid === 1'b1) && !rsp_stall;
      req_seen = req_data;
      rsp_seen = rsp_data;
   end

   // -------------------------------------------------------------------------
   // Predictor: executes one request beat on the shadow registers and returns
   // the result beat it must produce.
   // -------------------------------------------------------------------------
   function automatic rsp_type predict_alu(input req_type item);
      rsp_type           r;
      logic [5:0]        opcode, funct;
      logic [4:0]        rs, rt, rd, shamt;
      logic [DATA_W-1:0] a, b;
      bit                legal;
      r = '0;
      case (item.func)
         FUNC_EXEC: begin
            opcode = item.instruction[31:26];
            rs     = item.instruction[25:21];
            rt     = item.instruction[20:16];
            rd     = item.instruction[15:11];
            shamt  = item.instruction[10:6];
            funct  = item.instruction[5:0];
            if (opcode != OP_RTYPE) begin
               r.status = ST_NOT_R;
            end else begin
               a = shadow_regs[rs];
               b = shadow_regs[rt];
               legal = 1'b1;
               r.dest_index = rd;
               case (funct)
                  FN_ADD: begin
                     r.result_value = a + b;
                     // same operand signs, result sign differs
                     if (a[31] == b[31] && r.result_value[31] != a[31]) r.status = ST_OVF;
                  end
                  FN_SUB: begin
                     r.result_value = a - b;
                     if (a[31] != b[31] && r.result_value[31] != a[31]) r.status = ST_OVF;
                  end
                  FN_AND: r.result_value = a & b;
                  FN_OR:  r.result_value = a | b;
                  FN_SLL: r.result_value = b << shamt;
                  FN_SRL: r.result_value = b >> shamt;
                  FN_SLT: r.result_value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                  default: begin
                     legal    = 1'b0;
                     r.status = ST_BAD_FUNCT;
                  end
               endcase
               if (legal && r.status == ST_OK && rd != 0) begin
                  shadow_regs[rd] = r.result_value;
                  r.wrote = 1'b1;
               end
            end
         end
         FUNC_LOAD: begin
            r.dest_index   = item.reg_index;
            r.result_value = item.load_value;
            if (item.reg_index != 0) begin
               shadow_regs[item.reg_index] = item.load_value;
               r.wrote = 1'b1;
            end
         end
         FUNC_READ: begin
            r.dest_index   = item.reg_index;
            r.result_value = shadow_regs[item.reg_index];
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endfunction

   // -------------------------------------------------------------------------
   // Scoreboard: checks each result beat against the oldest prediction, then
   // queues the prediction for any request beat taken at this edge. A result always
   // trails its request by the execute stage and result register, so this order is safe.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_take) begin
         if (pending_rsp.size() == 0) begin
            $error("result beat with nothing expected: %p", rsp_seen);
            mismatches++;
         end else begin
            check_field("status",       32'(pending_rsp[0].status),     32'(rsp_seen.status));
            check_field("dest_index",   32'(pending_rsp[0].dest_index),
                        32'(rsp_seen.dest_index));
            check_field("result_value", pending_rsp[0].result_value, rsp_seen.result_value);
            check_field("wrote",        32'(pending_rsp[0].wrote),      32'(rsp_seen.wrote));
            void'(pending_rsp.pop_front());
         end
      end
      if (req_take) pending_rsp.push_back(predict_alu(req_seen));
   end

   // -------------------------------------------------------------------------
   // Receiver: random stall at about 36 percent when idling is on; a hold
   // request turns into a solid stall counted down here.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= rsp_idle_on && ($urandom_range(99) < 36);
      end
   end

   // Watchdog: any stretch with no beat on either side that is this long
   // means the block has hung.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (req_take || rsp_take) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("r_type_alu_register_file_test NOT OK");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Sender: called at a rising edge; holds the beat until it is taken, then
   // maybe drops valid for a random idle stretch. Valid that stays high is not
   // rewritten low in the same step.
   // -------------------------------------------------------------------------
   task automatic send_beat(input req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_take) @(posedge clock);
      if (sender_idle_on && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // instruction word with the R-type opcode
   function automatic logic [31:0] rword(input logic [4:0] rs, input logic [4:0] rt,
                                         input logic [4:0] rd, input logic [4:0] shamt,
                                         input logic [5:0] funct);
      return {OP_RTYPE, rs, rt, rd, shamt, funct};
   endfunction

   // Item builders; fields the kind ignores still carry random bits.
   function automatic req_type exec_item(input logic [31:0] word);
      req_type t;
      t.func        = FUNC_EXEC;
      t.instruction = word;
      t.reg_index   = 5'($urandom);
      t.load_value  = $urandom;
      return t;
   endfunction

   function automatic req_type reg_item(input logic [1:0] kind, input logic [4:0] idx,
                                        input logic [31:0] value);
      req_type t;
      t.func        = kind;
      t.instruction = $urandom;
      t.reg_index   = idx;
      t.load_value  = value;
      return t;
   endfunction

   // register number biased to the low eight so beats often depend on each other
   function automatic logic [4:0] pick_reg();
      return $urandom_range(1) ? 5'($urandom_range(7)) : 5'($urandom_range(31));
   endfunction

   // Random beat: mostly legal R-type work and loads, with some reads,
   // garbage words, bad functs and the ignored kind mixed in.
   function automatic req_type random_item();
      int          roll;
      logic [5:0]  funct;
      logic [31:0] value;
      roll = $urandom_range(99);
      case ($urandom_range(5))
         0: value = 32'h0000_0000;
         1: value = 32'h7FFF_FFFF;
         2: value = 32'h8000_0000;
         3: value = 32'hFFFF_FFFF;
         default: value = $urandom;
      endcase
      if (roll < 50) begin
         funct = alu_functs[$urandom_range(6)];
         return exec_item(rword(pick_reg(), pick_reg(), pick_reg(), 5'($urandom), funct));
      end else if (roll < 70) begin
         return reg_item(FUNC_LOAD, pick_reg(), value);
      end else if (roll < 85) begin
         return reg_item(FUNC_READ, pick_reg(), $urandom);
      end else if (roll < 93) begin
         return exec_item($urandom);
      end else if (roll < 97) begin
         do funct = 6'($urandom_range(63));
         while (funct inside {FN_SLL, FN_SRL, FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLT});
         return exec_item(rword(pick_reg(), pick_reg(), pick_reg(), 5'($urandom), funct));
      end else begin
         return reg_item(FUNC_IGNORED, 5'($urandom), $urandom);
      end
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Corners: overflow both ways (including a sum that wraps to zero),
   // shift extremes, slt by sign, register 0, bad opcode and funct.
   task automatic test_directed();
      send_beat(reg_item(FUNC_LOAD, 5'd1, 32'h7FFF_FFFF));
      send_beat(reg_item(FUNC_LOAD, 5'd2, 32'h0000_0001));
      send_beat(reg_item(FUNC_LOAD, 5'd3, 32'h8000_0000));
      send_beat(reg_item(FUNC_LOAD, 5'd4, 32'hFFFF_FFFF));
      send_beat(reg_item(FUNC_LOAD, 5'd0, 32'h1234_5678));   // ignored write
      send_beat(reg_item(FUNC_READ, 5'd0, 32'hFFFF_FFFF));
      send_beat(exec_item(rword(5'd1, 5'd2, 5'd5, 5'd0, FN_ADD)));   // max + 1
      send_beat(reg_item(FUNC_READ, 5'd5, 32'h0));                  // untouched
      send_beat(exec_item(rword(5'd3, 5'd3, 5'd6, 5'd0, FN_ADD)));   // wraps to zero
      send_beat(exec_item(rword(5'd3, 5'd2, 5'd7, 5'd0, FN_SUB)));   // min - 1
      send_beat(exec_item(rword(5'd1, 5'd4, 5'd8, 5'd0, FN_SUB)));   // max - (-1)
      send_beat(exec_item(rword(5'd2, 5'd1, 5'd9, 5'd0, FN_SUB)));
      send_beat(exec_item(rword(5'd4, 5'd2, 5'd10, 5'd0, FN_ADD)));  // -1 + 1
      send_beat(exec_item(rword(5'd1, 5'd4, 5'd11, 5'd0, FN_AND)));
      send_beat(exec_item(rword(5'd3, 5'd2, 5'd12, 5'd0, FN_OR)));
      send_beat(exec_item(rword(5'd0, 5'd4, 5'd13, 5'd31, FN_SLL)));
      send_beat(exec_item(rword(5'd0, 5'd4, 5'd14, 5'd31, FN_SRL)));
      send_beat(exec_item(rword(5'd0, 5'd1, 5'd15, 5'd0, FN_SLL)));
      send_beat(exec_item(rword(5'd3, 5'd2, 5'd16, 5'd0, FN_SLT)));  // negative < positive
      send_beat(exec_item(rword(5'd2, 5'd3, 5'd17, 5'd0, FN_SLT)));
      send_beat(exec_item(rword(5'd2, 5'd2, 5'd0, 5'd0, FN_ADD)));   // result to r0
      send_beat(exec_item(32'hFFFF_FFFF));                           // not R-type
      send_beat(exec_item(rword(5'd1, 5'd2, 5'd18, 5'd0, 6'h3F)));   // bad funct
      send_beat(reg_item(FUNC_IGNORED, 5'd31, 32'hFFFF_FFFF));
      send_beat(reg_item(FUNC_READ, 5'd16, 32'h0));
   endtask

   task automatic test_random(input int count);
      repeat (count) send_beat(random_item());
   endtask

   // No idling on either side: dependent beats back to back.
   task automatic test_back_to_back(input int count);
      sender_idle_on = 1'b0;
      rsp_idle_on    = 1'b0;
      test_random(count);
      sender_idle_on = 1'b1;
      rsp_idle_on    = 1'b1;
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering
   // beats, so the block fills and stalls its input.
   task automatic test_pressure(input int count);
      sender_idle_on = 1'b0;
      hold_request   = 1'b1;
      test_random(count);
      sender_idle_on = 1'b1;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(520);
      test_back_to_back(320);
      test_pressure(40);
      test_random(520);
      req_valid <= 1'b0;
      // drain, then keep running to catch any stray result beat
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("r_type_alu_register_file_test OK");
      end else begin
         $display("r_type_alu_register_file_test NOT OK");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/rtalu_pkg.sv
rtl/rtalu_ram.sv
rtl/rtalu_regfile.sv
rtl/rtalu_exec.sv
rtl/r_type_alu_register_file.sv
tb/sv/r_type_alu_register_file_test.sv
